// ----- rtl/svt_pkg.sv -----
// Shared constants, types and encoders for the singleton value tracker.
package svt_pkg;

  localparam int NUM_VALUES  = 4096;
  localparam int BLOCK_SIZE  = 64;
  localparam int COUNT_WIDTH = 16;

  localparam int NUM_BLOCKS = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int VAL_W      = $clog2(NUM_VALUES);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int OFF_W      = $clog2(BLOCK_SIZE);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic             in_range;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] off;
  } item_t;

  // Lowest set bit of the block flags.
  function automatic logic [BLK_W-1:0] first_blk(input logic [NUM_BLOCKS-1:0] b);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (b[i]) r = BLK_W'(i);
    end
    return r;
  endfunction

  // Lowest set bit of one singleton row.
  function automatic logic [OFF_W-1:0] first_off(input logic [BLOCK_SIZE-1:0] b);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
      if (b[i]) r = OFF_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/svt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module svt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- rtl/svt_front.sv -----
// Front end: accepts transactions, splits the value into block and offset, queues them.
module svt_front
  import svt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        hold,
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [15:0] s_data,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t     slot [2];
  logic      rd_ptr;
  logic      wr_ptr;
  logic [1:0] fill;
  item_t     incoming;
  logic      push;
  logic [VAL_W-1:0] v;

  always_comb begin
    v = s_data[VAL_W:1];
    incoming.op       = op_t'(s_data[0]);
    incoming.in_range = (32'(v) < NUM_VALUES);
    incoming.blk      = v[VAL_W-1 -: BLK_W];
    incoming.off      = v[OFF_W-1:0];
  end

  assign s_ready = (fill != 2'd2) && !hold;
  assign push    = s_valid && s_ready;
  assign q_valid = (fill != 2'd0);
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= incoming;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/svt_back.sv -----
// Back end: count update, singleton row update, two-level search and output register.
module svt_back
  import svt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  output logic        clearing,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        m_valid,
  input  logic        m_ready,
  output logic [15:0] m_data
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_UPD, S_SRCH, S_FIND} state_t;

  state_t           state;
  logic [VAL_W-1:0] clr;
  item_t            cur;
  status_t          status;
  logic [NUM_BLOCKS-1:0] nonempty;
  logic [BLK_W-1:0] fblk;
  logic             any;

  logic                   cnt_we;
  logic [VAL_W-1:0]       cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [COUNT_WIDTH-1:0] cnt_rdata;
  logic                   row_we;
  logic [BLK_W-1:0]       row_waddr;
  logic [BLOCK_SIZE-1:0]  row_wdata;
  logic                   row_re;
  logic [BLK_W-1:0]       row_raddr;
  logic [BLOCK_SIZE-1:0]  row_rdata;

  logic [COUNT_WIDTH-1:0] c_new;
  status_t                st_new;
  logic                   do_wr;
  logic [BLOCK_SIZE-1:0]  row_new;
  logic                   out_free;

  assign clearing = (state == S_CLR);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !m_valid || m_ready;

  always_comb begin
    c_new  = cnt_rdata;
    st_new = ST_OK;
    unique case (cur.op)
      OP_ADD: begin
        if (cnt_rdata == COUNT_MAX) st_new = ST_SAT;
        else c_new = cnt_rdata + COUNT_ONE;
      end
      OP_REMOVE: begin
        if (cnt_rdata == '0) st_new = ST_ABSENT;
        else c_new = cnt_rdata - COUNT_ONE;
      end
    endcase
    if (!cur.in_range) st_new = ST_OK;
    do_wr   = cur.in_range && (st_new == ST_OK);
    row_new = row_rdata;
    row_new[cur.off] = (c_new == COUNT_ONE);
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = {cur.blk, cur.off};
    cnt_wdata = c_new;
    row_we    = 1'b0;
    row_waddr = cur.blk;
    row_wdata = row_new;
    row_re    = 1'b0;
    row_raddr = q_item.blk;
    unique case (state)
      S_CLR: begin
        // sweep both stores to zero
        cnt_we    = 1'b1;
        cnt_waddr = clr;
        cnt_wdata = '0;
        row_we    = 1'b1;
        row_waddr = clr[BLK_W-1:0];
        row_wdata = '0;
      end
      S_IDLE: row_re = q_pop;
      S_UPD: begin
        cnt_we = do_wr;
        row_we = do_wr;
      end
      S_SRCH: begin
        row_re    = 1'b1;
        row_raddr = first_blk(nonempty);
      end
      S_FIND: ;
      default: ;
    endcase
  end

  svt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_VALUES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (q_pop),
    .raddr ({q_item.blk, q_item.off}),
    .rdata (cnt_rdata)
  );

  svt_ram #(.WIDTH(BLOCK_SIZE), .DEPTH(NUM_BLOCKS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr      <= '0;
      nonempty <= '0;
      m_valid  <= 1'b0;
    end else begin
      if (m_valid && m_ready && (state != S_FIND)) m_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + VAL_W'(1);
          if (32'(clr) == NUM_VALUES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cur   <= q_item;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          status <= st_new;
          if (do_wr) nonempty[cur.blk] <= |row_new;
          state <= S_SRCH;
        end
        S_SRCH: begin
          fblk  <= first_blk(nonempty);
          any   <= |nonempty;
          state <= S_FIND;
        end
        S_FIND: begin
          // hold until the output register is free
          if (out_free) begin
            m_valid <= 1'b1;
            m_data  <= {1'b0, status,
                        (any ? {fblk, first_off(row_rdata)} : VAL_W'(0)), any};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/singleton_value_tracker.sv -----
// Top level of the singleton value tracker.
// Keeps one occurrence count per value (0..4095) and a bitmap of values whose
// count is one, and after each add or remove reports the smallest such value.
// Each transaction passes through the back end as count read, count and
// bitmap write, block search with bitmap row read, and in-row search, and
// the next one is taken only once the result is registered. A two-entry
// queue in front and an output register let input and output stall on
// their own. After reset a clearing pass zeroes the count and bitmap
// memories, during which s_axis_tready stays low.
module singleton_value_tracker
  import svt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] op, [12:1] item_value, [15:13] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] found, [12:1] single_value, [14:13] status, [15] zero
);

  logic  clearing;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  svt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  svt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata)
  );

endmodule

// ----- rtl/svt_checker.sv -----
// Port-level assertions for the singleton value tracker, bound to the top level.
module svt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // the clearing pass follows every reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("value given without found");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[14:13] != 2'd3 && !m_axis_tdata[15])
    else $error("bad status or padding");

endmodule

bind singleton_value_tracker svt_checker u_svt_checker (.*);
